>>> rtl/rc4_pkg.sv
// Package for the RC4 stream cipher: constants, codes and the controller/datapath types.
`timescale 1ns / 1ps
package rc4_pkg;

    // Key storage limits.
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    // S-box geometry.
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_W     = 8;
    localparam int SBOX_AW    = $clog2(SBOX_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

    // Input command codes.
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_D1,
        ST_D2,
        ST_D3
    } t_rc4_state;

    // S-box read address selection.
    typedef enum logic [1:0] {
        RD_INC,
        RD_I,
        RD_J,
        RD_T
    } t_rc4_rsel;

    // S-box write address and data selection.
    typedef enum logic [1:0] {
        WR_INIT,
        WR_I_RD,
        WR_J_SI
    } t_rc4_wsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clr_idx;
        logic      inc_i;
        logic      ld_data;
        logic      rd_en;
        t_rc4_rsel rd_sel;
        logic      wr_en;
        t_rc4_wsel wr_sel;
        logic      ld_j;
        logic      add_key;
        logic      ld_si;
        logic      ld_sj;
        logic      adv_key;
        logic      ld_out;
    } t_rc4_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_i;
    } t_rc4_status;

endpackage

>>> rtl/rc4_if.sv
// Handshake interfaces of the RC4 stream cipher: input, output and configuration channels.
`timescale 1ns / 1ps

interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

interface rc4_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read of the address being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rc4_datapath.sv
// RC4 datapath: key registers, indexes, S-box RAM, swap bookkeeping and output byte register.
`timescale 1ns / 1ps
module rc4_datapath
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_rc4_cmd              i_cmd,
    output t_rc4_status           o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_data_byte,
    output logic [7:0]            o_out_byte
);

    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_length;
    logic [SBOX_AW-1:0]    r_i;
    logic [SBOX_AW-1:0]    r_j;
    logic [KEY_IDX_W-1:0]  r_k;
    logic [SBOX_W-1:0]     r_si;
    logic [SBOX_W-1:0]     r_sj;
    logic [SBOX_AW-1:0]    r_t;
    logic [7:0]            r_data;
    logic [7:0]            r_out_byte;

    logic [SBOX_AW-1:0]    n_j;
    logic [SBOX_AW-1:0]    ram_raddr;
    logic [SBOX_AW-1:0]    ram_waddr;
    logic [SBOX_W-1:0]     ram_wdata;
    logic [SBOX_W-1:0]     ram_rdata;
    logic [2*CFG_DATA_W-1:0] key_all;
    logic [7:0]            key_byte;
    logic [KEY_LEN_W-1:0]  len_eff;
    logic [SBOX_W-1:0]     keystream;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= KEY_LEN_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                REG_KEY_LENGTH: r_key_length <= i_cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Current key byte and the key length clamped to the supported range.
    assign key_all  = {r_key_high, r_key_low};
    assign key_byte = key_all[r_k*8 +: 8];

    always_comb begin
        if (r_key_length == '0) begin
            len_eff = KEY_LEN_W'(1);
        end else if (r_key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            len_eff = r_key_length;
        end
    end

    // Next j: j plus the S-box byte just read, plus the key byte during the key schedule.
    assign n_j = r_j + ram_rdata + (i_cmd.add_key ? key_byte : 8'd0);

    // S-box read address.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_INC:  ram_raddr = r_i + 8'd1;
            RD_I:    ram_raddr = r_i;
            RD_J:    ram_raddr = n_j;
            RD_T:    ram_raddr = r_si + ram_rdata;
            default: ram_raddr = r_i;
        endcase
    end

    // S-box write address and data.
    always_comb begin
        case (i_cmd.wr_sel)
            WR_INIT: begin
                ram_waddr = r_i;
                ram_wdata = r_i;
            end
            WR_I_RD: begin
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
            end
            WR_J_SI: begin
                ram_waddr = r_j;
                ram_wdata = r_si;
            end
            default: begin
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    rc4_ram #(
        .WIDTH (SBOX_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Indexes i, j and the key byte position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (i_cmd.clr_idx) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            if (i_cmd.inc_i) begin
                r_i <= r_i + 8'd1;
            end
            if (i_cmd.ld_j) begin
                r_j <= n_j;
            end
            if (i_cmd.adv_key) begin
                if ({1'b0, r_k} == len_eff - KEY_LEN_W'(1)) begin
                    r_k <= '0;
                end else begin
                    r_k <= r_k + KEY_IDX_W'(1);
                end
            end
        end
    end

    // Swap operands, keystream address, the data byte of the beat in flight and the output byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_si) begin
            r_si <= ram_rdata;
        end
        if (i_cmd.ld_sj) begin
            r_sj <= ram_rdata;
            r_t  <= r_si + ram_rdata;
        end
        if (i_cmd.ld_data) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.ld_out) begin
            r_out_byte <= r_data ^ keystream;
        end
    end

    // Keystream byte, forwarded from the swap when its address is one just swapped.
    always_comb begin
        if (r_t == r_j) begin
            keystream = r_si;
        end else if (r_t == r_i) begin
            keystream = r_sj;
        end else begin
            keystream = ram_rdata;
        end
    end

    assign o_status.last_i = (r_i == 8'hFF);
    assign o_out_byte      = r_out_byte;

endmodule

>>> rtl/rc4_ctrl.sv
// RC4 controller: sequences the key schedule and the per-byte swap, and owns the output valid.
`timescale 1ns / 1ps
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_cmd,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rc4_cmd    o_cmd,
    input  t_rc4_status i_status
);

    t_rc4_state r_state;
    t_rc4_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_I;
        o_cmd.wr_sel = WR_INIT;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_RESTART) begin
                        o_cmd.clr_idx = 1'b1;
                        n_state       = ST_INIT;
                    end else begin
                        o_cmd.ld_data = 1'b1;
                        o_cmd.inc_i   = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = RD_INC;
                        n_state       = ST_D1;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_INIT;
                o_cmd.inc_i  = 1'b1;
                if (i_status.last_i) begin
                    n_state = ST_K0;
                end
            end
            ST_K0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
                n_state      = ST_K1;
            end
            ST_K1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_J;
                o_cmd.ld_j    = 1'b1;
                o_cmd.add_key = 1'b1;
                o_cmd.ld_si   = 1'b1;
                n_state       = ST_K2;
            end
            ST_K2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_I_RD;
                n_state      = ST_K3;
            end
            ST_K3: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_J_SI;
                o_cmd.inc_i   = 1'b1;
                o_cmd.adv_key = 1'b1;
                if (i_status.last_i) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_K0;
                end
            end
            ST_D1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_J;
                o_cmd.ld_j   = 1'b1;
                o_cmd.ld_si  = 1'b1;
                n_state      = ST_D2;
            end
            ST_D2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_I_RD;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_T;
                o_cmd.ld_sj  = 1'b1;
                n_state      = ST_D3;
            end
            ST_D3: begin
                // Rewriting the same entry while the output is full is harmless.
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_J_SI;
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid is set by a new result and cleared when the beat is taken.
    always_comb begin
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: controller, datapath and channel hookup.
//
// Usage: write key_low (index 0), key_high (index 1) and key_length (index 2)
// on the configuration channel while the block is idle; it is always ready.
// Then send a restart beat (cmd = 1) on the input channel. It runs the key
// schedule and gives no output: an identity fill of the S-box RAM and 256
// scramble steps, each through the states K0, K1, K2 and K3; no new input
// beat is taken until it ends. Register changes apply at the next restart.
// Each data beat (cmd = 0) then gives one output beat, the byte XORed with
// the keystream byte; encryption and decryption are the same operation.
// A data beat runs through the states IDLE, D1, D2 and D3, an order set by the
// three dependent reads and the two swap writes on the S-box RAM, which has
// one read and one write port. No new byte is taken before D3 loads the result.
// The result sits in an output register; a new input beat is taken while it
// waits, and the data beat's last step holds until that register is free.
// Reset clears the indexes, the controller and the output valid and sets the
// key length to 5; the S-box holds no defined contents until a restart.
`timescale 1ns / 1ps
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rc4_in_if.sink    i_in,
    rc4_out_if.source o_out,
    rc4_cfg_if.sink   i_cfg
);

    t_rc4_cmd    cmd;
    t_rc4_status status;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    rc4_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_data_byte (i_in.data_byte),
        .o_out_byte  (o_out.out_byte)
    );

endmodule

>>> tb/rc4_stream_cipher_test.sv
// Self-checking testbench for the RC4 stream cipher: scoreboard with its own keystream predictor.
`timescale 1ns / 1ps
module rc4_stream_cipher_test;
    import rc4_pkg::*;

    // Run limits and waits, in clock cycles.
    localparam int unsigned CYCLE_LIMIT       = 2000000;
    localparam int unsigned KEY_SCHEDULE_WAIT = 1281 + 64;
    localparam int unsigned END_SETTLE        = 24;
    localparam int unsigned HOLD_CYCLES       = 300;
    localparam int unsigned SEGMENT_ITEMS     = 230;

    // An index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Scoreboard: keeps its own copy of the key registers, S-box and indexes,
    // and holds the output bytes still owed by the block.
    class rc4_keystream_board;
        logic [63:0]         key_low_q;
        logic [63:0]         key_high_q;
        logic [KEY_LEN_W-1:0] key_len_q;
        logic [7:0]          sbox_q [SBOX_DEPTH];
        logic [7:0]          idx_i;
        logic [7:0]          idx_j;
        logic [7:0]          expected_bytes [$];
        int unsigned         mismatches;

        function new();
            key_low_q   = '0;
            key_high_q  = '0;
            key_len_q   = 5'd5;
            idx_i       = '0;
            idx_j       = '0;
            mismatches  = 0;
            foreach (sbox_q[n]) sbox_q[n] = '0;
        endfunction

        // Register writes only land in the key registers; the S-box follows
        // them at the next restart.
        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
            case (index)
                REG_KEY_LOW:    key_low_q  = value;
                REG_KEY_HIGH:   key_high_q = value;
                REG_KEY_LENGTH: key_len_q  = value[KEY_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Identity fill followed by the 256-step key scramble.
        function void schedule_key();
            logic [127:0] key_bits;
            int unsigned  len;
            int unsigned  k;
            logic [7:0]   j;
            logic [7:0]   t;
            key_bits = {key_high_q, key_low_q};
            len = key_len_q;
            if (len == 0) len = 1;
            if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
            for (int n = 0; n < SBOX_DEPTH; n++) sbox_q[n] = 8'(n);
            j = '0;
            k = 0;
            for (int n = 0; n < SBOX_DEPTH; n++) begin
                j = j + sbox_q[n] + key_bits[8*k +: 8];
                t = sbox_q[n];
                sbox_q[n] = sbox_q[j];
                sbox_q[j] = t;
                k = (k + 1 >= len) ? 0 : k + 1;
            end
            idx_i = '0;
            idx_j = '0;
        endfunction

        // Called for every accepted input beat.
        function void note_beat(logic cmd, logic [7:0] data_value);
            logic [7:0] t;
            logic [7:0] ks_index;
            if (cmd == CMD_RESTART) begin
                schedule_key();
            end else begin
                idx_i = idx_i + 8'd1;
                idx_j = idx_j + sbox_q[idx_i];
                t = sbox_q[idx_i];
                sbox_q[idx_i] = sbox_q[idx_j];
                sbox_q[idx_j] = t;
                ks_index = sbox_q[idx_i] + sbox_q[idx_j];
                expected_bytes.push_back(data_value ^ sbox_q[ks_index]);
            end
        endfunction

        // Called for every accepted output beat.
        function void check_byte(logic [7:0] actual);
            logic [7:0] expected;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected out_byte, expected none, actual %02h", $time, actual);
                mismatches++;
            end else begin
                expected = expected_bytes.pop_front();
                if (actual !== expected) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, expected, actual);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rc4_in_if  in_if ();
    rc4_out_if out_if ();
    rc4_cfg_if cfg_if ();

    rc4_stream_cipher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    rc4_keystream_board board;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned out_hold_request;
    int unsigned cycle_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: a hang ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[rc4_stream_cipher] ERROR");
        $finish;
    end

    // Monitor: every accepted beat on the three channels goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) board.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) board.note_beat(in_if.cmd, in_if.data_byte);
            if (out_if.valid && out_if.ready) board.check_byte(out_if.out_byte);
        end
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int unsigned hold_left;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold_request != 0) begin
                hold_left = out_hold_request;
                out_hold_request = 0;
                out_if.ready = 1'b0;
                while (hold_left != 0) begin
                    @(negedge i_clk);
                    hold_left--;
                end
            end
            out_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one input beat after an optional random gap and waits for it to be taken.
    task automatic send_beat(input logic cmd, input logic [7:0] data_value);
        int unsigned gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.cmd       = cmd;
        in_if.data_byte = data_value;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Writes one configuration register.
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Stops offering input until every owed output byte has arrived.
    task automatic drain_results();
        in_if.valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A restart gives no output, so after draining allow a full key schedule
    // to finish before touching the registers.
    task automatic settle_for_config();
        drain_results();
        repeat (KEY_SCHEDULE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Random key, with lengths that favor the ends of the range and the
    // out-of-range values that the block clamps.
    task automatic load_random_key();
        logic [4:0] len;
        case ($urandom_range(9))
            0: len = 5'd1;
            1: len = 5'd16;
            2: len = 5'd0;
            3: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 16));
        endcase
        write_key_reg(REG_KEY_LOW, random_word());
        write_key_reg(REG_KEY_HIGH, random_word());
        if ($urandom_range(3) == 0) write_key_reg(REG_UNUSED, random_word());
        write_key_reg(REG_KEY_LENGTH, {59'd0, len});
    endtask

    // Mostly restart-then-data sequences; a few stray restarts break runs apart.
    // One long output hold-off and one full drain fall somewhere inside.
    task automatic run_segment(input int unsigned item_budget);
        int unsigned sent;
        int unsigned run_len;
        int unsigned hold_at;
        int unsigned drain_at;
        bit          held;
        bit          drained;
        sent     = 0;
        held     = 1'b0;
        drained  = 1'b0;
        hold_at  = $urandom_range(10, item_budget / 2);
        drain_at = $urandom_range(item_budget / 2, item_budget - 10);
        while (sent < item_budget) begin
            send_beat(CMD_RESTART, 8'($urandom_range(255)));
            sent++;
            run_len = $urandom_range(4, 60);
            if (run_len > item_budget - sent) run_len = item_budget - sent;
            repeat (run_len) begin
                if (!held && sent >= hold_at) begin
                    out_hold_request = HOLD_CYCLES;
                    held = 1'b1;
                end
                if (!drained && sent >= drain_at) begin
                    drain_results();
                    drained = 1'b1;
                end
                if ($urandom_range(99) < 3) send_beat(CMD_RESTART, 8'($urandom_range(255)));
                else send_beat(CMD_DATA, 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // Short directed pass over reset values, key-length edges and data extremes.
    task automatic run_directed();
        // Reset key values: zero key, five bytes.
        send_beat(CMD_RESTART, 8'h00);
        send_beat(CMD_DATA, 8'h00);

        // Longest key, all ones in the high half.
        settle_for_config();
        write_key_reg(REG_KEY_LOW, 64'h0);
        write_key_reg(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key_reg(REG_KEY_LENGTH, 64'd16);
        send_beat(CMD_RESTART, 8'hFF);
        send_beat(CMD_DATA, 8'h00);
        send_beat(CMD_DATA, 8'hFF);
        send_beat(CMD_DATA, 8'h55);
        send_beat(CMD_DATA, 8'hAA);

        // New key written mid-stream must not disturb the running keystream;
        // a zero length is used as one byte at the following restart.
        settle_for_config();
        write_key_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key_reg(REG_KEY_LENGTH, 64'd0);
        send_beat(CMD_DATA, 8'h5A);
        send_beat(CMD_DATA, 8'hA5);
        send_beat(CMD_RESTART, 8'h00);
        send_beat(CMD_DATA, 8'h00);
        send_beat(CMD_DATA, 8'hFF);

        // Length above the maximum saturates; the unused index changes nothing.
        settle_for_config();
        write_key_reg(REG_KEY_LENGTH, 64'd31);
        write_key_reg(REG_UNUSED, 64'h0123_4567_89AB_CDEF);
        write_key_reg(REG_KEY_HIGH, 64'h0F1E_2D3C_4B5A_6978);
        send_beat(CMD_RESTART, 8'h00);
        send_beat(CMD_DATA, 8'h01);
        send_beat(CMD_DATA, 8'h80);
        send_beat(CMD_DATA, 8'h7F);

        // Single-byte key and two restarts back to back.
        settle_for_config();
        write_key_reg(REG_KEY_LOW, 64'h8000_0000_0000_00C3);
        write_key_reg(REG_KEY_LENGTH, 64'd1);
        send_beat(CMD_RESTART, 8'h00);
        send_beat(CMD_RESTART, 8'hFF);
        send_beat(CMD_DATA, 8'hFE);
        send_beat(CMD_DATA, 8'h00);
    endtask

    // Main sequence.
    initial begin
        board            = new();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        out_hold_request = 0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.cmd        = CMD_DATA;
        in_if.data_byte  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_KEY_LOW;
        cfg_if.data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        // Three idling profiles, two key settings each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 51;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 15;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (2) begin
                settle_for_config();
                load_random_key();
                run_segment(SEGMENT_ITEMS);
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("[rc4_stream_cipher] OK");
        end else begin
            $display("[rc4_stream_cipher] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_ram.sv
rtl/rc4_datapath.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_test.sv
